// ----- src/wbpm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wbpm_pkg
// Shared constants, types and helpers of the masked byte signature scanner.
// ----------------------------------------------------------------------------
package wbpm_pkg;

	// Window depth in cells (1 to 16)
	localparam int MAX_PATTERN = 16;

	// Fixed field widths
	localparam int BYTE_W  = 8;
	localparam int ADDR_W  = 64;
	localparam int WORD_W  = 64;
	localparam int CARE_W  = 16;
	localparam int LEN_W   = 5;
	localparam int PIDX_W  = 4;
	localparam int CNT_W   = $clog2(MAX_PATTERN + 1);

	// Configuration register indexes
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_PAT_LOW  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_PAT_HIGH = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_CARE     = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_LENGTH   = 2'd3;

	// Per-cell control from the top level
	typedef struct packed {
		logic              shift;
		logic              active;
		logic              care;
		logic [BYTE_W-1:0] pat;
	} cell_ctrl_t;

	// Pick pattern byte idx out of the two pattern words
	function automatic logic [BYTE_W-1:0] pattern_byte(
		input logic [WORD_W-1:0] low,
		input logic [WORD_W-1:0] high,
		input logic [PIDX_W-1:0] idx
	);
		logic [WORD_W-1:0] word;
		word = idx[3] ? high : low;
		return word[idx[2:0]*BYTE_W +: BYTE_W];
	endfunction

endpackage
`default_nettype wire

// ----- src/wbpm_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wbpm_cell
// One window cell: holds one byte, passes it on at each shift and compares
// it against the pattern byte that lines up with it.
// ----------------------------------------------------------------------------
module wbpm_cell (
	input  wire logic                       clk,
	input  wire wbpm_pkg::cell_ctrl_t       ctrl,
	input  wire logic [wbpm_pkg::BYTE_W-1:0] byte_in,
	output logic      [wbpm_pkg::BYTE_W-1:0] byte_out,
	output logic                            ok
);
	import wbpm_pkg::*;

	logic [BYTE_W-1:0] byte_q;

	// Take the neighbor's byte when an item comes in
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			byte_q <= byte_in;
		end
	end

	assign byte_out = byte_q;

	// Pass when unused, wildcard, or equal
	assign ok = !ctrl.active || !ctrl.care || (byte_q == ctrl.pat);

endmodule
`default_nettype wire

// ----- src/wildcard_byte_pattern_matcher_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_matcher_core
// Streaming scanner for a byte signature with wildcard positions.
// ----------------------------------------------------------------------------
// The block takes one memory byte per cycle and reports the address of the
// first byte of every window of pattern_length bytes, all from one region,
// whose cared positions equal the pattern. An item is accepted every cycle
// while results are taken. A byte that is accepted is first shifted into the
// cell chain; then all cells are compared in parallel and the address is
// registered. A result that waits on out_stall holds the output register; the
// next item still enters, and only an item that itself matches behind a
// stalled result stalls the input.
// Configuration writes take effect at once and are meant for idle periods.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_matcher_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// configuration
	input  wire logic                           cfg_write,
	input  wire logic [wbpm_pkg::REG_IDX_W-1:0] cfg_index,
	input  wire logic [wbpm_pkg::WORD_W-1:0]    cfg_data,
	// input items
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [wbpm_pkg::BYTE_W-1:0]    data_byte,
	input  wire logic [wbpm_pkg::ADDR_W-1:0]    byte_address,
	input  wire logic                           region_first,
	// result items
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic      [wbpm_pkg::ADDR_W-1:0]    match_address
);
	import wbpm_pkg::*;

	logic [WORD_W-1:0] pat_low_q;
	logic [WORD_W-1:0] pat_high_q;
	logic [CARE_W-1:0] care_q;
	logic [LEN_W-1:0]  len_q;

	logic [CNT_W-1:0]  count_q;
	logic              valid_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              out_valid_q;
	logic [ADDR_W-1:0] match_address_q;

	logic              accept_in;
	logic              out_free;
	logic              hit;
	logic              len_ok;
	logic [MAX_PATTERN-1:0] cell_ok;
	logic [BYTE_W-1:0] cell_byte [MAX_PATTERN];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			care_q     <= '0;
			len_q      <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_PAT_LOW:  pat_low_q  <= cfg_data;
				REG_PAT_HIGH: pat_high_q <= cfg_data;
				REG_CARE:     care_q     <= cfg_data[CARE_W-1:0];
				REG_LENGTH:   len_q      <= cfg_data[LEN_W-1:0];
				default:      ;
			endcase
		end
	end

	// Handshake
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && hit && !out_free;
	assign accept_in = in_valid && !in_stall;

	// Cell chain
	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
		cell_ctrl_t        ctrl;
		logic [PIDX_W-1:0] pidx;
		logic [BYTE_W-1:0] byte_in;

		// Pattern position that lines up with this cell
		assign pidx         = PIDX_W'(len_q - LEN_W'(k) - LEN_W'(1));
		assign ctrl.shift   = accept_in;
		assign ctrl.active  = LEN_W'(k) < len_q;
		assign ctrl.care    = care_q[pidx];
		assign ctrl.pat     = pattern_byte(pat_low_q, pat_high_q, pidx);

		if (k == 0) begin : g_head
			assign byte_in = data_byte;
		end else begin : g_link
			assign byte_in = cell_byte[k-1];
		end

		wbpm_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.byte_in  (byte_in),
			.byte_out (cell_byte[k]),
			.ok       (cell_ok[k])
		);
	end

	// Region fill count and stage one control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept_in) begin
				if (region_first) begin
					count_q <= CNT_W'(1);
				end else if (count_q < CNT_W'(MAX_PATTERN)) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (accept_in) begin
				valid_s1 <= 1'b1;
			end else if (!in_stall) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Hold the address of the newest byte
	always_ff @(posedge clk) begin
		if (accept_in) begin
			addr_s1 <= byte_address;
		end
	end

	// Match decision on the window after the newest byte
	assign len_ok = (len_q != '0) && (len_q <= LEN_W'(MAX_PATTERN))
		&& (LEN_W'(count_q) >= len_q);
	assign hit = len_ok && (&cell_ok);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1 && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1 && hit) begin
			match_address_q <= addr_s1 - ADDR_W'(len_q) + ADDR_W'(1);
		end
	end

	assign out_valid     = out_valid_q;
	assign match_address = match_address_q;

endmodule
`default_nettype wire

// ----- src/wbpm_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wbpm_checker
// Port-level checks of the scanner core, bound to the top level.
// ----------------------------------------------------------------------------
module wbpm_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           in_stall,
	input wire logic                           out_valid,
	input wire logic                           out_stall,
	input wire logic [wbpm_pkg::ADDR_W-1:0]    match_address
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(match_address))
		else $error("stalled result changed or dropped");

	// Stall the input only behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled result");

	// A waiting match moves out once the output frees up
	a_pending_moves: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall ##1 !out_stall |=> out_valid)
		else $error("waiting match lost");

endmodule

bind wildcard_byte_pattern_matcher_core wbpm_checker u_wbpm_checker (.*);
`default_nettype wire
